/* sv/dmxr_pkg.sv */
package dmxr_pkg;

    localparam int SLOT_COUNT_DEF = 512;
    localparam int FUNC_W         = 3;
    localparam int BYTE_W         = 8;
    localparam int IDX_W          = 10;
    localparam int TICK_W         = 24;
    localparam int MODE_W         = 2;
    localparam int S_DATA_W       = 32;
    localparam int M_DATA_W       = 16;

    localparam logic [TICK_W-1:0] TICK_MAX          = '1;
    localparam logic [TICK_W-1:0] HEALTHY_TICKS_RST = TICK_W'(1000);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE    = 3'd0,
        FUNC_BREAK      = 3'd1,
        FUNC_LINE_ERROR = 3'd2,
        FUNC_HOST_READ  = 3'd3,
        FUNC_HOST_WRITE = 3'd4,
        FUNC_TICK       = 3'd5
    } func_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BREAK = 2'd1,
        MODE_DATA  = 2'd2
    } mode_t;

    // Status of one word after its state update
    typedef struct packed {
        logic              rd_ok;
        logic              new_packet;
        logic              healthy;
        logic [MODE_W-1:0] rx_mode;
    } status_t;

endpackage

/* sv/dmxr_slot_mem.sv */
module dmxr_slot_mem #(
    parameter int SLOT_COUNT = dmxr_pkg::SLOT_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [$clog2(SLOT_COUNT+1)-1:0]     wr_addr,
    input  logic [dmxr_pkg::BYTE_W-1:0]         wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(SLOT_COUNT+1)-1:0]     rd_addr,
    output logic [dmxr_pkg::BYTE_W-1:0]         rd_data,
    output logic                                clr_busy
);
    import dmxr_pkg::*;

    localparam int DEPTH  = SLOT_COUNT + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_busy_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;

    // Sweep zeros through the store after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

/* sv/dmxr_ctrl.sv */
module dmxr_ctrl #(
    parameter int SLOT_COUNT = dmxr_pkg::SLOT_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dmxr_pkg::TICK_W-1:0]         cfg_data,
    input  logic                                in_accept,
    input  logic [dmxr_pkg::FUNC_W-1:0]         in_func,
    input  logic [dmxr_pkg::BYTE_W-1:0]         in_rx_byte,
    input  logic [dmxr_pkg::IDX_W-1:0]          in_slot_index,
    input  logic [dmxr_pkg::BYTE_W-1:0]         in_write_data,
    output logic                                mem_wr_en,
    output logic [$clog2(SLOT_COUNT+1)-1:0]     mem_wr_addr,
    output logic [dmxr_pkg::BYTE_W-1:0]         mem_wr_data,
    output logic                                mem_rd_en,
    output logic [$clog2(SLOT_COUNT+1)-1:0]     mem_rd_addr,
    output dmxr_pkg::status_t                   status
);
    import dmxr_pkg::*;

    localparam int DEPTH  = SLOT_COUNT + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    mode_t             mode_reg,  mode_next;
    logic [CNT_W-1:0]  addr_reg,  addr_next;
    logic              flag_reg,  flag_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [TICK_W-1:0] healthy_ticks_reg;
    logic              in_range;
    logic              rd_ok;

    assign in_range = (in_slot_index >= IDX_W'(1)) && (in_slot_index <= IDX_W'(SLOT_COUNT));

    always_comb begin
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        flag_next   = flag_reg;
        ticks_next  = ticks_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = in_slot_index[ADDR_W-1:0];
        mem_wr_data = in_write_data;
        rd_ok       = 1'b0;
        if (in_accept) begin
            unique case (in_func)
                FUNC_RX_BYTE: begin
                    if (mode_reg == MODE_BREAK) begin
                        if (in_rx_byte == '0) begin
                            mode_next  = MODE_DATA;
                            addr_next  = '0;
                            ticks_next = '0;
                        end else begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    // store until the slot store is full, drop the rest
                    if (mode_next == MODE_DATA && addr_next < CNT_W'(DEPTH)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = addr_next[ADDR_W-1:0];
                        mem_wr_data = in_rx_byte;
                        addr_next   = addr_next + CNT_W'(1);
                        flag_next   = 1'b1;
                    end
                end
                FUNC_BREAK:      mode_next = MODE_BREAK;
                FUNC_LINE_ERROR: mode_next = MODE_IDLE;
                FUNC_HOST_READ: begin
                    if (in_range) begin
                        rd_ok     = 1'b1;
                        flag_next = 1'b0;
                    end
                end
                FUNC_HOST_WRITE: begin
                    if (in_range) begin
                        mem_wr_en = 1'b1;
                    end
                end
                FUNC_TICK: begin
                    if (ticks_reg != TICK_MAX) begin
                        ticks_next = ticks_reg + TICK_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_IDLE;
            addr_reg          <= '0;
            flag_reg          <= 1'b0;
            ticks_reg         <= TICK_MAX;
            healthy_ticks_reg <= HEALTHY_TICKS_RST;
        end else begin
            mode_reg  <= mode_next;
            addr_reg  <= addr_next;
            flag_reg  <= flag_next;
            ticks_reg <= ticks_next;
            if (cfg_we) begin
                healthy_ticks_reg <= cfg_data;
            end
        end
    end

    assign mem_rd_en   = rd_ok;
    assign mem_rd_addr = in_slot_index[ADDR_W-1:0];

    assign status.rd_ok      = rd_ok;
    assign status.new_packet = flag_next;
    assign status.healthy    = ticks_next < healthy_ticks_reg;
    assign status.rx_mode    = mode_next;

endmodule

/* sv/dmx512_receiver_slot_store.sv */
// DMX512 receiver with a slot store of SLOT_COUNT+1 bytes (start code at slot 0).
// Input channel s_*: one event word per handshake; s_tuser carries the event kind
// (rx byte, break, line error, host read, host write, tick), s_tdata its operands.
// Result channel m_*: exactly one result word per event word, in order, holding
// the read data (zero unless a host read hit slots 1 to SLOT_COUNT), the
// new-packet flag, the health flag and the receiver mode after the event.
// Configuration channel cfg_*: writes the health window in ticks; always ready.
// Path: an accepted word passes through the middle stage, then the result
// register that drives m_tvalid. Throughput: one word per cycle while the
// receiver takes results and no clearing pass runs; the slot store's single
// read port and write port serve every event in the cycle it is accepted.
// Reset (aresetn low, synchronous): receiver idle, flags clear, tick count
// saturated, health window 1000. A clearing pass then zeroes the store, one
// slot a cycle through all SLOT_COUNT+1 slots, with s_tready low.
// Receiver stall: m_tdata holds; one more word is held in the middle stage,
// after which s_tready drops until the receiver takes a word.
module dmx512_receiver_slot_store #(
    parameter int SLOT_COUNT = dmxr_pkg::SLOT_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] rx_byte, [17:8] slot_index, [25:18] write_data, [31:26] zero
    input  logic [dmxr_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] func
    input  logic [dmxr_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] read_data, [8] new_packet, [9] healthy, [11:10] rx_mode, [15:12] zero
    output logic [dmxr_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    // [23:0] healthy_ticks
    input  logic [dmxr_pkg::TICK_W-1:0]   cfg_data
);
    import dmxr_pkg::*;

    localparam int ADDR_W = $clog2(SLOT_COUNT + 1);

    logic              s_accept;
    logic              clr_busy;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [BYTE_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;
    status_t           status;

    // Middle stage: status of the accepted word, read data in the memory register
    logic              a_valid_reg;
    status_t           a_stat_reg;
    logic              a_adv;

    // Result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [BYTE_W-1:0]   rd_value;

    assign cfg_ready = 1'b1;
    assign a_adv     = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !clr_busy && (!a_valid_reg || a_adv);
    assign s_accept  = s_tvalid && s_tready;

    dmxr_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .in_accept     (s_accept),
        .in_func       (s_tuser),
        .in_rx_byte    (s_tdata[7:0]),
        .in_slot_index (s_tdata[17:8]),
        .in_write_data (s_tdata[25:18]),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .status        (status)
    );

    dmxr_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .clr_busy (clr_busy)
    );

    // Zero the read data unless the word was an in-range host read
    assign rd_value = a_stat_reg.rd_ok ? mem_rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // advance the middle stage, hold it while the result register is full and not taken
            if (s_accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            a_stat_reg <= status;
        end
        if (a_adv) begin
            m_data_reg <= {4'b0, a_stat_reg.rx_mode, a_stat_reg.healthy,
                           a_stat_reg.new_packet, rd_value};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("word accepted during store clearing");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> a_valid_reg)
        else $error("accepted word lost before middle stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !a_adv) |=> (a_valid_reg && $stable(a_stat_reg)))
        else $error("stalled middle stage changed");

    a_adv_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv |=> m_valid_reg)
        else $error("result register not loaded");
`endif

endmodule
